[rtl/core/assert_macros.svh]
// Assertion helpers used by mws_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MWS_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mws assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mws assertion failed");

`endif

[rtl/core/mws_pkg.sv]
package mws_pkg;

   localparam int ARM_WIDTH             = 13;
   localparam int MAX_WIDTH             = 15;
   localparam int SPEED_WIDTH_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 12;
   localparam int LANES                 = 4;
   localparam int DIV_STEP_BITS         = 2;
   localparam int CSR_INDEX_WIDTH       = 4;
   localparam int CSR_DATA_WIDTH        = 16;

   localparam logic [ARM_WIDTH-1:0] ARM_RESET = 13'd1819;
   localparam logic [MAX_WIDTH-1:0] MAX_RESET = 15'd16384;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARM_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_SPEED  = 4'd1;

   // Width of the rounded lever-arm term magnitude.
   function automatic int turn_width(int sw, int f);
      return ARM_WIDTH + sw + 1 - f;
   endfunction

   // Width of a wheel speed magnitude before limiting.
   function automatic int mag_width(int sw, int f);
      int a;
      a = (sw + 1 > turn_width(sw, f)) ? sw + 1 : turn_width(sw, f);
      return a + 1;
   endfunction

endpackage

[rtl/core/mws_kinematics.sv]
module mws_kinematics #(
   parameter int SPEED_WIDTH   = mws_pkg::SPEED_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mws_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [SPEED_WIDTH-1:0]                        speed_x,
   input  logic [SPEED_WIDTH-1:0]                        speed_y,
   input  logic [SPEED_WIDTH-1:0]                        yaw_rate,
   input  logic [mws_pkg::ARM_WIDTH-1:0]                 arm_length,
   input  logic [mws_pkg::MAX_WIDTH-1:0]                 max_speed,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [mws_pkg::LANES-1:0][mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)-1:0] out_mag,
   output logic [mws_pkg::LANES-1:0]                     out_neg,
   output logic [mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)-1:0] out_largest,
   output logic                                          out_limited
);

   localparam int SW = SPEED_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int AW = mws_pkg::ARM_WIDTH;
   localparam int MW = mws_pkg::MAX_WIDTH;
   localparam int L  = mws_pkg::LANES;
   localparam int PW = AW + SW;
   localparam int LW = mws_pkg::mag_width(SW, F);
   localparam int WW = LW + 1;
   localparam int CW = (LW > MW) ? LW : MW;

   localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   logic [SW-1:0]        wz_mag;
   logic signed [SW:0]   pp_in, pm_in, pp_ff, pm_ff;
   logic [PW-1:0]        prod_in, prod_ff;
   logic                 wz_neg_ff;

   logic [PW:0]          rnd;
   logic [WW-1:0]        turn_ext, turn, ppx, pmx;
   logic [L-1:0][WW-1:0] wheel_in, wheel_ff;

   logic [L-1:0][WW-1:0] abs_w;
   logic [L-1:0][LW-1:0] mag_in, mag_ff;
   logic [L-1:0]         neg_in, neg_ff;
   logic [LW-1:0]        l01, l23, largest_in, largest_ff;
   logic                 limited_in, limited_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: chassis sums and lever-arm product
   always_comb begin
      wz_mag  = yaw_rate[SW-1] ? (~yaw_rate + SW'(1)) : yaw_rate;
      pp_in   = $signed({speed_x[SW-1], speed_x}) + $signed({speed_y[SW-1], speed_y});
      pm_in   = $signed({speed_x[SW-1], speed_x}) - $signed({speed_y[SW-1], speed_y});
      prod_in = PW'(arm_length) * PW'(wz_mag);
   end

   // Stage 2: round the turn term and form the four wheels
   always_comb begin
      rnd         = {1'b0, prod_ff} + HALF;
      turn_ext    = WW'(rnd[PW:F]);
      turn        = wz_neg_ff ? (~turn_ext + WW'(1)) : turn_ext;
      ppx         = WW'(pp_ff);
      pmx         = WW'(pm_ff);
      wheel_in[0] = pmx - turn;
      wheel_in[1] = ppx - turn;
      wheel_in[2] = (WW'(0) - pmx) - turn;
      wheel_in[3] = (WW'(0) - ppx) - turn;
   end

   // Stage 3: magnitudes, largest and the limit decision
   always_comb begin
      for (int i = 0; i < L; i++) begin
         neg_in[i] = wheel_ff[i][WW-1];
         abs_w[i]  = neg_in[i] ? (~wheel_ff[i] + WW'(1)) : wheel_ff[i];
         mag_in[i] = abs_w[i][LW-1:0];
      end
      l01        = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      l23        = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
      largest_in = (l01 > l23) ? l01 : l23;
      limited_in = CW'(largest_in) > CW'(max_speed);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pp_ff     <= pp_in;
         pm_ff     <= pm_in;
         prod_ff   <= prod_in;
         wz_neg_ff <= yaw_rate[SW-1];
      end
      if (rdy2) begin
         wheel_ff <= wheel_in;
      end
      if (rdy3) begin
         mag_ff     <= mag_in;
         neg_ff     <= neg_in;
         largest_ff <= largest_in;
         limited_ff <= limited_in;
      end
   end

   assign out_valid   = v3_ff;
   assign out_mag     = mag_ff;
   assign out_neg     = neg_ff;
   assign out_largest = largest_ff;
   assign out_limited = limited_ff;

endmodule

[rtl/core/mws_div_stage.sv]
module mws_div_stage #(
   parameter int SPEED_WIDTH   = mws_pkg::SPEED_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mws_pkg::FRACTION_BITS_DEFAULT,
   parameter int TOP_BIT       = mws_pkg::MAX_WIDTH - 1,
   parameter int STEPS         = mws_pkg::DIV_STEP_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [mws_pkg::LANES-1:0][mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)
                                     + mws_pkg::MAX_WIDTH + 1:0] in_rem,
   input  logic [mws_pkg::LANES-1:0][mws_pkg::MAX_WIDTH-1:0] in_quo,
   input  logic [mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS):0] in_div,
   input  logic [mws_pkg::LANES-1:0][mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)-1:0] in_mag,
   input  logic [mws_pkg::LANES-1:0] in_neg,
   input  logic in_limited,
   output logic out_valid,
   input  logic out_ready,
   output logic [mws_pkg::LANES-1:0][mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)
                                     + mws_pkg::MAX_WIDTH + 1:0] out_rem,
   output logic [mws_pkg::LANES-1:0][mws_pkg::MAX_WIDTH-1:0] out_quo,
   output logic [mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS):0] out_div,
   output logic [mws_pkg::LANES-1:0][mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS)-1:0] out_mag,
   output logic [mws_pkg::LANES-1:0] out_neg,
   output logic out_limited
);

   localparam int L  = mws_pkg::LANES;
   localparam int LW = mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS);
   localparam int QW = mws_pkg::MAX_WIDTH;
   localparam int RW = LW + QW + 2;
   localparam int DW = LW + 1;

   logic                 valid_ff;
   logic [L-1:0][RW-1:0] rem_in, rem_ff;
   logic [L-1:0][QW-1:0] quo_in, quo_ff;
   logic [DW-1:0]        div_ff;
   logic [L-1:0][LW-1:0] mag_ff;
   logic [L-1:0]         neg_ff;
   logic                 limited_ff;

   assign in_ready = !valid_ff || out_ready;

   // Restoring division, one quotient bit per step, high bit first
   always_comb begin
      logic [RW-1:0] r;
      logic [RW-1:0] dsh;
      logic [QW-1:0] q;
      for (int i = 0; i < L; i++) begin
         r = in_rem[i];
         q = in_quo[i];
         for (int j = 0; j < STEPS; j++) begin
            dsh = RW'(in_div) << (TOP_BIT - j);
            if (r >= dsh) begin
               r = r - dsh;
               q = {q[QW-2:0], 1'b1};
            end else begin
               q = {q[QW-2:0], 1'b0};
            end
         end
         rem_in[i] = r;
         quo_in[i] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         div_ff     <= in_div;
         mag_ff     <= in_mag;
         neg_ff     <= in_neg;
         limited_ff <= in_limited;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rem     = rem_ff;
   assign out_quo     = quo_ff;
   assign out_div     = div_ff;
   assign out_mag     = mag_ff;
   assign out_neg     = neg_ff;
   assign out_limited = limited_ff;

endmodule

[rtl/core/mecanum_wheel_speed_limiter_core.sv]
// Mecanum wheel speed limiter.
// Request channel (req_valid / req_stall) carries one chassis command: sideways
// speed, forward speed and yaw rate, signed fixed point. Response channel
// (rsp_valid / rsp_stall) returns the four wheel speeds and a limited flag,
// one response per request, in request order.
// csr_valid / csr_ready writes arm_length (index 0) and max_speed
// (index 1); csr_ready is always high. Write only while no request is in flight.
// From request to response the pipeline holds three kinematics stages, one
// scaling multiply, the divider stages (two quotient bits each, one in the last
// stage, fifteen bits for the scale ratio), and the saturating output register.
// Throughput: one request per cycle. Each stage has its own valid bit and
// advances when the stage after it is empty or moving, so a stalled response
// backs the pipeline up stage by stage and bubbles are squeezed out; req_stall
// rises only once the first stage cannot move.
// Reset clears all valid bits and loads arm_length = 1819 and
// max_speed = 16384.
module mecanum_wheel_speed_limiter_core #(
   parameter int SPEED_WIDTH   = mws_pkg::SPEED_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mws_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SPEED_WIDTH-1:0]       req_speed_x,
   input  logic signed [SPEED_WIDTH-1:0]       req_speed_y,
   input  logic signed [SPEED_WIDTH-1:0]       req_yaw_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SPEED_WIDTH-1:0]       rsp_wheel_a,
   output logic signed [SPEED_WIDTH-1:0]       rsp_wheel_b,
   output logic signed [SPEED_WIDTH-1:0]       rsp_wheel_c,
   output logic signed [SPEED_WIDTH-1:0]       rsp_wheel_d,
   output logic                                rsp_limited,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mws_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mws_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SW   = SPEED_WIDTH;
   localparam int L    = mws_pkg::LANES;
   localparam int AW   = mws_pkg::ARM_WIDTH;
   localparam int MW   = mws_pkg::MAX_WIDTH;
   localparam int QW   = mws_pkg::MAX_WIDTH;
   localparam int B    = mws_pkg::DIV_STEP_BITS;
   localparam int LW   = mws_pkg::mag_width(SPEED_WIDTH, FRACTION_BITS);
   localparam int NW   = LW + MW;
   localparam int RW   = NW + 2;
   localparam int DW   = LW + 1;
   localparam int VW   = (LW > QW) ? LW : QW;
   localparam int NSTG = (QW + B - 1) / B;

   localparam logic [VW-1:0] NEG_LIMIT = VW'(1) << (SW - 1);
   localparam logic [VW-1:0] POS_LIMIT = NEG_LIMIT - VW'(1);

   // Configuration registers
   logic [AW-1:0] arm_length_ff;
   logic [MW-1:0] max_speed_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_length_ff <= mws_pkg::ARM_RESET;
         max_speed_ff  <= mws_pkg::MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mws_pkg::CSR_ARM_LENGTH: arm_length_ff <= csr_wdata[AW-1:0];
            mws_pkg::CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[MW-1:0];
            default: ;
         endcase
      end
   end

   // Kinematics, stages 1 to 3
   logic                 kin_ready, kin_valid;
   logic [L-1:0][LW-1:0] kin_mag;
   logic [L-1:0]         kin_neg;
   logic [LW-1:0]        kin_largest;
   logic                 kin_limited;
   logic                 m_ready;

   mws_kinematics #(
      .SPEED_WIDTH   (SPEED_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_kinematics (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (kin_ready),
      .speed_x         (req_speed_x),
      .speed_y         (req_speed_y),
      .yaw_rate        (req_yaw_rate),
      .arm_length      (arm_length_ff),
      .max_speed       (max_speed_ff),
      .out_valid       (kin_valid),
      .out_ready       (m_ready),
      .out_mag         (kin_mag),
      .out_neg         (kin_neg),
      .out_largest     (kin_largest),
      .out_limited     (kin_limited)
   );

   assign req_stall = !kin_ready;

   // Stage 4: dividend 2*mag*max + largest, divisor 2*largest (rounds to nearest)
   logic                 m_valid_ff;
   logic [L-1:0][RW-1:0] m_rem_in, m_rem_ff;
   logic [DW-1:0]        m_div_ff;
   logic [L-1:0][LW-1:0] m_mag_ff;
   logic [L-1:0]         m_neg_ff;
   logic                 m_limited_ff;
   logic [L-1:0][NW-1:0] m_num;

   logic [NSTG:0]                 dv_valid, dv_ready;
   logic [L-1:0][RW-1:0]          dv_rem     [NSTG+1];
   logic [L-1:0][QW-1:0]          dv_quo     [NSTG+1];
   logic [DW-1:0]                 dv_div     [NSTG+1];
   logic [L-1:0][LW-1:0]          dv_mag     [NSTG+1];
   logic [L-1:0]                  dv_neg     [NSTG+1];
   logic [NSTG:0]                 dv_limited;

   assign m_ready = !m_valid_ff || dv_ready[0];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         m_num[i]    = NW'(kin_mag[i]) * NW'(max_speed_ff);
         m_rem_in[i] = RW'({m_num[i], 1'b0}) + RW'(kin_largest);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_ready) begin
         m_valid_ff <= kin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready) begin
         m_rem_ff     <= m_rem_in;
         m_div_ff     <= {kin_largest, 1'b0};
         m_mag_ff     <= kin_mag;
         m_neg_ff     <= kin_neg;
         m_limited_ff <= kin_limited;
      end
   end

   assign dv_valid[0]   = m_valid_ff;
   assign dv_rem[0]     = m_rem_ff;
   assign dv_quo[0]     = '0;
   assign dv_div[0]     = m_div_ff;
   assign dv_mag[0]     = m_mag_ff;
   assign dv_neg[0]     = m_neg_ff;
   assign dv_limited[0] = m_limited_ff;

   // Divider stages
   for (genvar s = 0; s < NSTG; s++) begin : g_div
      localparam int TB = QW - 1 - s * B;
      localparam int ST = (TB + 1 < B) ? TB + 1 : B;

      mws_div_stage #(
         .SPEED_WIDTH   (SPEED_WIDTH),
         .FRACTION_BITS (FRACTION_BITS),
         .TOP_BIT       (TB),
         .STEPS         (ST)
      ) u_div_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (dv_valid[s]),
         .in_ready    (dv_ready[s]),
         .in_rem      (dv_rem[s]),
         .in_quo      (dv_quo[s]),
         .in_div      (dv_div[s]),
         .in_mag      (dv_mag[s]),
         .in_neg      (dv_neg[s]),
         .in_limited  (dv_limited[s]),
         .out_valid   (dv_valid[s+1]),
         .out_ready   (dv_ready[s+1]),
         .out_rem     (dv_rem[s+1]),
         .out_quo     (dv_quo[s+1]),
         .out_div     (dv_div[s+1]),
         .out_mag     (dv_mag[s+1]),
         .out_neg     (dv_neg[s+1]),
         .out_limited (dv_limited[s+1])
      );
   end

   // Output stage: pick scaled or raw magnitude, restore sign, saturate
   logic                 o_ready;
   logic                 rsp_valid_ff;
   logic [L-1:0][SW-1:0] wheel_in, wheel_ff;
   logic                 limited_ff;
   logic [L-1:0][VW-1:0] o_mag;
   logic [L-1:0][VW-1:0] o_negv;

   assign o_ready          = !rsp_valid_ff || !rsp_stall;
   assign dv_ready[NSTG]   = o_ready;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         o_mag[i]  = dv_limited[NSTG] ? VW'(dv_quo[NSTG][i]) : VW'(dv_mag[NSTG][i]);
         o_negv[i] = ~o_mag[i] + VW'(1);
         if (dv_neg[NSTG][i]) begin
            wheel_in[i] = (o_mag[i] > NEG_LIMIT) ? NEG_LIMIT[SW-1:0] : o_negv[i][SW-1:0];
         end else begin
            wheel_in[i] = (o_mag[i] > POS_LIMIT) ? POS_LIMIT[SW-1:0] : o_mag[i][SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ready) begin
         rsp_valid_ff <= dv_valid[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready) begin
         wheel_ff   <= wheel_in;
         limited_ff <= dv_limited[NSTG];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wheel_a = wheel_ff[0];
   assign rsp_wheel_b = wheel_ff[1];
   assign rsp_wheel_c = wheel_ff[2];
   assign rsp_wheel_d = wheel_ff[3];
   assign rsp_limited = limited_ff;

endmodule

[rtl/core/mws_checker.sv]
`include "assert_macros.svh"

module mws_checker #(
   parameter int SPEED_WIDTH = mws_pkg::SPEED_WIDTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SPEED_WIDTH-1:0] rsp_wheel_a,
   input logic [SPEED_WIDTH-1:0] rsp_wheel_b,
   input logic [SPEED_WIDTH-1:0] rsp_wheel_c,
   input logic [SPEED_WIDTH-1:0] rsp_wheel_d,
   input logic                   rsp_limited,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   localparam int SW = SPEED_WIDTH;
   localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
   localparam logic [SW-1:0] S_MAX = ~S_MIN;

   logic [7:0] pend_ff;
   logic       req_take, rsp_take;
   logic       sat_any;
   logic signed [SW+1:0] sum_ac, sum_bd;
   logic [4*SW:0] rsp_bundle;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track requests in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 8'd0;
      end else if (req_take && !rsp_take) begin
         pend_ff <= pend_ff + 8'd1;
      end else if (rsp_take && !req_take) begin
         pend_ff <= pend_ff - 8'd1;
      end
   end

   assign rsp_bundle = {rsp_wheel_a, rsp_wheel_b, rsp_wheel_c, rsp_wheel_d, rsp_limited};
   assign sum_ac  = (SW + 2)'($signed(rsp_wheel_a)) + (SW + 2)'($signed(rsp_wheel_c));
   assign sum_bd  = (SW + 2)'($signed(rsp_wheel_b)) + (SW + 2)'($signed(rsp_wheel_d));
   assign sat_any = (rsp_wheel_a == S_MIN) || (rsp_wheel_a == S_MAX)
                 || (rsp_wheel_b == S_MIN) || (rsp_wheel_b == S_MAX)
                 || (rsp_wheel_c == S_MIN) || (rsp_wheel_c == S_MAX)
                 || (rsp_wheel_d == S_MIN) || (rsp_wheel_d == S_MAX);

   `MWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bundle))
   `MWS_ASSERT(a_no_orphan, clock, reset, rsp_valid, pend_ff != 8'd0)
   `MWS_ASSERT(a_empty_takes, clock, reset, pend_ff == 8'd0, !req_stall)
   `MWS_ASSERT(a_wheel_balance, clock, reset, rsp_valid && !rsp_limited && !sat_any, sum_ac == sum_bd)
   `MWS_ASSERT(a_csr_always_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind mecanum_wheel_speed_limiter_core mws_checker #(
   .SPEED_WIDTH (SPEED_WIDTH)
) u_mws_checker (.*);
